/* rtl/itda_pkg.sv */
// Shared types and constants for the signed integer to decimal text converter.
`timescale 1ns / 1ps

package itda_pkg;

  localparam int DATA_WIDTH_DEF = 32;

  localparam logic [6:0] CH_ZERO  = 7'd48;
  localparam logic [6:0] CH_MINUS = 7'd45;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } itda_state_t;

  // Commands from the sequencer to the shift/add-3 unit.
  typedef struct packed {
    logic load;
    logic dabble;
    logic shift_digit;
  } itda_cmd_t;

endpackage

/* rtl/itda_bcd_unit.sv */
// Shift and add-3 unit: converts a binary magnitude to packed BCD one bit a cycle.
`timescale 1ns / 1ps

module itda_bcd_unit import itda_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int NUM_DIGITS = (DATA_WIDTH * 30103) / 100000 + 1
) (
  input  logic                  clk,
  input  itda_cmd_t             cmd,
  input  logic [DATA_WIDTH-1:0] mag_in,
  output logic [3:0]            top_digit,
  output logic                  top_zero
);

  localparam int BcdW = 4 * NUM_DIGITS;

  logic [DATA_WIDTH-1:0] mag;
  logic [BcdW-1:0]       bcd;
  logic [BcdW-1:0]       bcd_adj;

  // Every digit that is five or more gets three added before the shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag <= mag_in;
      bcd <= '0;
    end else if (cmd.dabble) begin
      {bcd, mag} <= {bcd_adj[BcdW-2:0], mag, 1'b0};
    end else if (cmd.shift_digit) begin
      bcd <= {bcd[BcdW-5:0], 4'd0};
    end
  end

  assign top_digit = bcd[BcdW-1 -: 4];
  assign top_zero  = (top_digit == 4'd0);

endmodule

/* rtl/signed_int_to_decimal_ascii.sv */
// Top level of the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps

// Converts one two's-complement integer per transaction into its decimal text,
// sent one ASCII character per output transaction, most significant first, with
// a leading '-' for negative values and last_char set on the final character.
// A single shift/add-3 unit builds the BCD digits at one input bit per cycle,
// then leading zero digits are shifted out, the last digit always kept, and
// the sign, if any, and the digits are sent as the receiver takes them. The
// input is taken only while the converter is idle; the final character may
// still wait in the output register when the next input is accepted.
module signed_int_to_decimal_ascii import itda_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DATA_WIDTH-1:0] value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [6:0]            char_code,
  output logic                  last_char
);

  localparam int NumDigits = (DATA_WIDTH * 30103) / 100000 + 1;
  localparam int BitCntW   = $clog2(DATA_WIDTH + 1);
  localparam int DigCntW   = $clog2(NumDigits + 1);

  itda_state_t           state, state_next;
  logic [BitCntW-1:0]    bit_cnt, bit_cnt_next;
  logic [DigCntW-1:0]    dig_cnt, dig_cnt_next;
  logic                  neg, neg_next;
  logic                  out_valid_next;
  logic                  out_load;
  logic [6:0]            out_char;
  logic                  out_last;
  logic                  slot_free;
  itda_cmd_t             cmd;
  logic [DATA_WIDTH-1:0] mag_in;
  logic [3:0]            top_digit;
  logic                  top_zero;

  // The most negative value negates to itself, which read unsigned is its magnitude.
  assign mag_in = value[DATA_WIDTH-1] ? (~value + 1'b1) : value;

  itda_bcd_unit #(
    .DATA_WIDTH (DATA_WIDTH),
    .NUM_DIGITS (NumDigits)
  ) u_bcd (
    .clk       (clk),
    .cmd       (cmd),
    .mag_in    (mag_in),
    .top_digit (top_digit),
    .top_zero  (top_zero)
  );

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    bit_cnt <= bit_cnt_next;
    dig_cnt <= dig_cnt_next;
    neg     <= neg_next;
    if (out_load) begin
      char_code <= out_char;
      last_char <= out_last;
    end
  end

  always_comb begin
    state_next   = state;
    bit_cnt_next = bit_cnt;
    dig_cnt_next = dig_cnt;
    neg_next     = neg;
    cmd          = '0;
    in_ready     = 1'b0;
    out_load     = 1'b0;
    out_char     = CH_ZERO + {3'd0, top_digit};
    out_last     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load     = 1'b1;
          neg_next     = value[DATA_WIDTH-1];
          bit_cnt_next = BitCntW'(DATA_WIDTH);
          state_next   = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.dabble   = 1'b1;
        bit_cnt_next = bit_cnt - 1'b1;
        if (bit_cnt == BitCntW'(1)) begin
          dig_cnt_next = DigCntW'(NumDigits);
          state_next   = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // Drop leading zeros, but always keep the last digit.
        if (top_zero && dig_cnt != DigCntW'(1)) begin
          cmd.shift_digit = 1'b1;
          dig_cnt_next    = dig_cnt - 1'b1;
        end else if (neg) begin
          state_next = ST_SIGN;
        end else begin
          state_next = ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_load   = 1'b1;
          out_char   = CH_MINUS;
          state_next = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (slot_free) begin
          out_load        = 1'b1;
          out_last        = (dig_cnt == DigCntW'(1));
          cmd.shift_digit = 1'b1;
          dig_cnt_next    = dig_cnt - 1'b1;
          if (dig_cnt == DigCntW'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

/* rtl/itda_checker.sv */
// Port-level checks for the decimal ASCII converter, bound to its top level.
`timescale 1ns / 1ps

module itda_checker import itda_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] char_code,
  input logic       last_char
);

  // A character that is not taken stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(char_code) && $stable(last_char))
    else $error("output character changed while stalled");

  // Only a minus sign or a decimal digit is ever sent.
  a_char_set: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> char_code == CH_MINUS ||
                  (char_code >= CH_ZERO && char_code <= CH_ZERO + 7'd9))
    else $error("output character is neither a minus sign nor a digit");

  // A minus sign is always followed by at least one digit.
  a_sign_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && char_code == CH_MINUS |-> !last_char)
    else $error("minus sign marked as last character");

  // In the cycle after an input transaction the converter is busy.
  a_busy_after_input: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a conversion is under way");

  // The conversion keeps the input closed once the first busy cycle has passed.
  a_no_output_while_idle_start: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> ##1 !in_ready)
    else $error("converter ready again too soon after an input transaction");

endmodule

bind signed_int_to_decimal_ascii itda_checker u_itda_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .char_code (char_code),
  .last_char (last_char)
);

/* verif/tb_signed_int_to_decimal_ascii.sv */
// Testbench for the signed integer to decimal ASCII converter, checked against a built-in predictor.
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii;
  import itda_pkg::*;

  localparam int W           = DATA_WIDTH_DEF;
  localparam int MAX_CYCLES  = 600000;
  localparam int DRAIN_WAIT  = 80;
  localparam int HOLD_CYCLES = 400;
  localparam int NUM_RANDOM  = 145;

  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } ascii_char_t;

  // Holds the characters still owed by the block, oldest first.
  class digit_scoreboard;
    ascii_char_t pending_chars[$];
    int          mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Work out the decimal text of an accepted value and queue its characters.
    function void note_value(logic [W-1:0] v);
      logic [W-1:0] mag;
      logic         neg;
      logic [3:0]   digs[24];
      int           nd;
      ascii_char_t  ch;
      neg = v[W-1];
      // The most negative value wraps to 2^(W-1), which is right as unsigned.
      mag = neg ? (~v + 1'b1) : v;
      nd = 0;
      do begin
        digs[nd] = 4'(mag % 10);
        nd++;
        mag = mag / 10;
      end while (mag != 0);
      if (neg) begin
        ch.code = CH_MINUS;
        ch.last = 1'b0;
        pending_chars.push_back(ch);
      end
      for (int k = nd - 1; k >= 0; k--) begin
        ch.code = CH_ZERO + 7'(digs[k]);
        ch.last = (k == 0);
        pending_chars.push_back(ch);
      end
    endfunction

    function void check_char(logic [6:0] code, logic last);
      ascii_char_t exp_ch;
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected character: code %0d last %0b", code, last);
        return;
      end
      exp_ch = pending_chars.pop_front();
      if (code !== exp_ch.code || last !== exp_ch.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("character mismatch: expected code %0d last %0b, got code %0d last %0b",
                   exp_ch.code, exp_ch.last, code, last);
      end
    endfunction
  endclass

  logic         clk       = 1'b0;
  logic         rst       = 1'b1;
  logic         in_valid  = 1'b0;
  logic [W-1:0] value     = '0;
  logic         out_ready = 1'b0;
  logic         in_ready;
  logic         out_valid;
  logic [6:0]   char_code;
  logic         last_char;

  digit_scoreboard sb = new();
  int              accepted_count = 0;
  int              cycle_count = 0;
  logic            stall_on = 1'b0;

  signed_int_to_decimal_ascii #(.DATA_WIDTH(W)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .char_code (char_code),
    .last_char (last_char)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == MAX_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_char(char_code, last_char);
  end

  // Receiver: runs of full readiness, random readiness and short or long hold-offs.
  initial begin
    int run_len;
    int mode;
    forever begin
      mode = $urandom_range(0, 9);
      if (mode < 3) run_len = $urandom_range(20, 100);
      else if (mode < 7) run_len = $urandom_range(10, 60);
      else if (mode < 9) run_len = $urandom_range(1, 3);
      else run_len = $urandom_range(20, 50);
      repeat (run_len) begin
        @(posedge clk);
        if (stall_on || rst) out_ready <= 1'b0;
        else if (mode < 3) out_ready <= 1'b1;
        else if (mode < 7) out_ready <= $urandom_range(0, 1);
        else out_ready <= 1'b0;
      end
    end
  end

  // Long receiver hold-off while the sender keeps offering, so the input stalls.
  initial begin
    wait (accepted_count >= 30);
    @(posedge clk);
    stall_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    stall_on <= 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // Full-range words and values of a random digit count, with edges around powers of ten mixed in.
  function automatic logic [W-1:0] pick_value();
    longint pow10[11];
    longint lo;
    longint hi;
    longint mag;
    int     nd;
    int     r;
    logic   neg;
    pow10[0] = 1;
    for (int i = 1; i <= 10; i++) pow10[i] = pow10[i-1] * 10;
    r = $urandom_range(0, 99);
    if (r < 40) return W'($urandom());
    neg = $urandom_range(0, 1);
    if (r < 85) begin
      nd = $urandom_range(1, 10);
      lo = (nd == 1) ? 0 : pow10[nd-1];
      hi = pow10[nd] - 1;
      if (neg && hi > 64'd2147483648) hi = 64'd2147483648;
      if (!neg && hi > 64'd2147483647) hi = 64'd2147483647;
      mag = lo + longint'($urandom_range(0, int'(hi - lo)));
    end else begin
      nd = $urandom_range(1, 9);
      mag = pow10[nd] + $urandom_range(0, 2) - 1;
    end
    return neg ? W'(-mag) : W'(mag);
  endfunction

  task automatic send_value(logic [W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    // The ready level is taken as it stands at the edge itself.
    @(posedge clk iff in_ready);
    sb.note_value(v);
    accepted_count++;
  endtask

  initial begin
    logic [W-1:0] directed[$];
    directed = '{
      32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
      32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h7FFF_FFFE,
      32'd999999999, 32'd1000000000, -32'sd1000000000, -32'sd999999999,
      32'd1234567890, -32'sd1234567890, 32'h5555_5555, 32'hAAAA_AAAA,
      32'd1000000001, -32'sd9, 32'd7, 32'd4294967286, 32'd0
    };
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (directed[i]) send_value(directed[i]);
    repeat (NUM_RANDOM) send_value(pick_value());
    in_valid <= 1'b0;
    while (sb.pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_chars.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

/* signed_int_to_decimal_ascii.f */
rtl/itda_pkg.sv
rtl/itda_bcd_unit.sv
rtl/signed_int_to_decimal_ascii.sv
rtl/itda_checker.sv
verif/tb_signed_int_to_decimal_ascii.sv
